FILE: src/ali_pkg.sv
// ----------------------------------------------------------------------------
// ali_pkg: shared types and constants for the array list block
// Operation codes, sequencer states, cell control and scan status.
// ----------------------------------------------------------------------------
package ali_pkg;

  localparam int VAL_W     = 32;  // entry / key width
  localparam int POS_W     = 7;   // insert position field
  localparam int MODE_W    = 2;   // operation field
  localparam int OUT_IDX_W = 6;   // found_index field
  localparam int OUT_LEN_W = 7;   // list_length field
  localparam int SCAN_GRP  = 16;  // hit bits examined per scan cycle (power of two)
  localparam int SCAN_LW   = $clog2(SCAN_GRP);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic ins;  // shift up from sel_idx, load key at sel_idx
    logic del;  // shift down onto sel_idx
    logic cmp;  // register key compare into hit bit
  } cell_ctl_t;

  // first-match scanner status
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

FILE: src/ali_cell.sv
// ----------------------------------------------------------------------------
// ali_cell: one storage cell of the list
// Holds one entry, shifts to/from its neighbors, compares against the key.
// ----------------------------------------------------------------------------
module ali_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 6,
  parameter int LEN_W = 7
) (
  input  logic                     clk,
  input  ali_pkg::cell_ctl_t       ctl,
  input  logic [ali_pkg::VAL_W-1:0] key,
  input  logic [IDX_W-1:0]         sel_idx,
  input  logic [LEN_W-1:0]         len,
  input  logic [ali_pkg::VAL_W-1:0] from_lo,  // entry of cell INDEX-1
  input  logic [ali_pkg::VAL_W-1:0] from_hi,  // entry of cell INDEX+1
  output logic [ali_pkg::VAL_W-1:0] entry,
  output logic                     hit
);
  import ali_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [LEN_W-1:0] MY_LEN = LEN_W'(INDEX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX > sel_idx) begin
        entry <= from_lo;
      end else if (MY_IDX == sel_idx) begin
        entry <= key;
      end
    end else if (ctl.del && (MY_IDX >= sel_idx)) begin
      entry <= from_hi;
    end
  end

  // only occupied cells may report a match
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= (entry == key) && (MY_LEN < len);
    end
  end

endmodule

FILE: src/ali_scan.sv
// ----------------------------------------------------------------------------
// ali_scan: first-match finder
// Walks the registered hit vector one group per cycle, lowest group first.
// ----------------------------------------------------------------------------
module ali_scan #(
  parameter int IDX_W = 6,
  parameter int NGRP  = 4,
  parameter int GW    = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [NGRP*ali_pkg::SCAN_GRP-1:0] hits,
  output ali_pkg::scan_stat_t               stat,
  output logic [IDX_W-1:0]                  idx
);
  import ali_pkg::*;

  logic                busy;
  logic [GW-1:0]       grp;
  logic [SCAN_GRP-1:0] grp_bits [NGRP];
  logic [SCAN_GRP-1:0] cur;
  logic [SCAN_LW-1:0]  loc;
  logic                last;

  for (genvar g = 0; g < NGRP; g++) begin : g_split
    assign grp_bits[g] = hits[g*SCAN_GRP +: SCAN_GRP];
  end

  assign cur  = grp_bits[grp];
  assign last = (grp == GW'(NGRP - 1));

  // lowest set bit of the current group
  always_comb begin
    loc = '0;
    for (int i = SCAN_GRP - 1; i >= 0; i--) begin
      if (cur[i]) begin
        loc = SCAN_LW'(i);
      end
    end
  end

  assign stat.found = busy && (cur != '0);
  assign stat.done  = busy && ((cur != '0) || last);
  assign idx        = IDX_W'({grp, loc});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (stat.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      grp <= '0;
    end else if (busy && !stat.done) begin
      grp <= grp + GW'(1);
    end
  end

endmodule

FILE: src/array_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_search: ordered list of 32-bit values
// Insert at position, delete first match, search first match.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transfer: mode in tuser, value and
//   insert position in tdata. m_axis returns exactly one result per
//   operation: ok in tuser, found index and new length in tdata.
//   Entries live in a row of DEPTH cells. Insert shifts the cells above the
//   position up by one; delete shifts the cells above the match down by
//   one. Search and delete register a compare in every cell, then a scanner
//   walks the hit bits 16 cells per cycle to find the first match; that
//   scanner sets the delete/search time.
//   An accepted operation passes from the EXEC state to FIN; delete and
//   search go through SCAN in between, which walks the hit groups, lowest
//   first, and stops at the group holding a match or at the last group.
//   FIN loads the result register and raises m_axis_tvalid once m_axis is free.
//   One operation is in flight at a time; s_axis_tready returns the cycle
//   after the result register is loaded.
//   The next operation is accepted while an earlier result still waits on
//   m_axis; a stalled receiver only holds the block once a new result is
//   ready to be loaded. Reset empties the list (length 0) and drops any
//   pending result; entry contents are not cleared.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] item_value, [38:32] position, zero pad
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] found_index, [12:6] list_length, zero pad
  output logic [0:0]  m_axis_tuser    // [0] ok
);
  import ali_pkg::*;

  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int NGRP  = (DEPTH + SCAN_GRP - 1) / SCAN_GRP;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NPAD  = NGRP * SCAN_GRP;

  state_t state, state_next;

  // operation latched at the input transfer
  mode_t             op_mode;
  logic [VAL_W-1:0]  op_key;
  logic [POS_W-1:0]  op_pos;

  logic [LEN_W-1:0]  length;
  logic              res_ok;
  logic [IDX_W-1:0]  res_idx;

  logic              out_ok;
  logic [OUT_IDX_W-1:0] out_idx;
  logic [OUT_LEN_W-1:0] out_len;

  logic              in_xfer;
  logic              slot_free;
  logic              ins_ok;
  logic              is_cmp;

  cell_ctl_t         ctl;
  logic [IDX_W-1:0]  sel_idx;
  logic              scan_start;
  scan_stat_t        scan_st;
  logic [IDX_W-1:0]  scan_idx;

  logic [VAL_W-1:0]  ent [DEPTH];
  logic [NPAD-1:0]   hits;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  // insert fits: position within the list and a free cell left
  assign ins_ok    = (CMP_W'(op_pos) <= CMP_W'(length)) && (length < LEN_W'(DEPTH));
  assign is_cmp    = (op_mode == MODE_DELETE) || (op_mode == MODE_SEARCH);

  // --------------------------------------------------------------------------
  // cell row
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lo, hi;
    if (i == 0) begin : g_first
      assign lo = op_key;
    end else begin : g_mid_lo
      assign lo = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi = ent[i];
    end else begin : g_mid_hi
      assign hi = ent[i+1];
    end

    ali_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .key     (op_key),
      .sel_idx (sel_idx),
      .len     (length),
      .from_lo (lo),
      .from_hi (hi),
      .entry   (ent[i]),
      .hit     (hits[i])
    );
  end

  if (NPAD > DEPTH) begin : g_pad
    assign hits[NPAD-1:DEPTH] = '0;
  end

  ali_scan #(
    .IDX_W (IDX_W),
    .NGRP  (NGRP),
    .GW    (GW)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .hits  (hits),
    .stat  (scan_st),
    .idx   (scan_idx)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = is_cmp ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        if (scan_st.done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    scan_start    = 1'b0;
    ctl           = '0;
    sel_idx       = IDX_W'(op_pos);
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_EXEC: begin
        ctl.ins    = (op_mode == MODE_INSERT) && ins_ok;
        ctl.cmp    = is_cmp;
        scan_start = is_cmp;
      end
      ST_SCAN: begin
        ctl.del = scan_st.found && (op_mode == MODE_DELETE);
        sel_idx = scan_idx;
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      length        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.ins) begin
        length <= length + LEN_W'(1);
      end else if (ctl.del) begin
        length <= length - LEN_W'(1);
      end
      if ((state == ST_FIN) && slot_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_mode <= mode_t'(s_axis_tuser);
      op_key  <= s_axis_tdata[VAL_W-1:0];
      op_pos  <= s_axis_tdata[VAL_W +: POS_W];
    end
    if (state == ST_EXEC) begin
      res_ok  <= (op_mode == MODE_INSERT) && ins_ok;
      res_idx <= ((op_mode == MODE_INSERT) && ins_ok) ? IDX_W'(op_pos) : '0;
    end else if ((state == ST_SCAN) && scan_st.done) begin
      res_ok  <= scan_st.found;
      res_idx <= scan_st.found ? scan_idx : '0;
    end
    if ((state == ST_FIN) && slot_free) begin
      out_ok  <= res_ok;
      out_idx <= OUT_IDX_W'(res_idx);
      out_len <= OUT_LEN_W'(length);
    end
  end

  assign m_axis_tuser = out_ok;
  assign m_axis_tdata = {3'b000, out_len, out_idx};

`ifndef SYNTHESIS
  // length never runs past the cell count
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(DEPTH))
    else $error("list length exceeds DEPTH");

  // at most one cell operation per cycle
  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.ins, ctl.del, ctl.cmp}))
    else $error("conflicting cell controls");

  // scanner only finishes while the sequencer waits on it
  a_scan_owner: assert property (@(posedge clk) disable iff (rst)
    scan_st.done |-> (state == ST_SCAN))
    else $error("scan finished outside scan state");

  // a failed operation reports index zero
  a_fail_idx: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[5:0] == '0))
    else $error("nonzero index on failure");
`endif

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for array_list_insert_delete_search
// Drives insert/delete/search/unused operations over the s_axis stream, keeps
// a shadow list in a queue, and checks every m_axis result field by field.
// A short directed table comes first, then fill/drain/mixed random phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ali_pkg::*;

  localparam int          LIST_CAP    = 64;     // DEPTH of the block under test
  localparam logic [1:0]  MODE_UNUSED = 2'd3;   // no operation, length echoed
  localparam int          RAND_OPS    = 1450;
  localparam int          HOLD_CYCLES = 300;    // receiver back-pressure stretch
  localparam int          DRAIN_WAIT  = 16;     // extra wait once all results are in

  typedef enum int {PROF_FILL, PROF_MIX, PROF_DRAIN} phase_prof_t;

  // one expected m_axis transfer
  typedef struct {
    logic                 ok;
    logic [OUT_IDX_W-1:0] idx;
    logic [OUT_LEN_W-1:0] len;
  } list_outcome_t;

  // one s_axis transfer, optionally with a hand-written expectation
  typedef struct {
    logic [MODE_W-1:0]    op;
    logic [VAL_W-1:0]     val;
    logic [POS_W-1:0]     pos;
    bit                   typed;
    logic                 ok;
    logic [OUT_IDX_W-1:0] idx;
    logic [OUT_LEN_W-1:0] len;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [31:0] item_value, [38:32] position, zero pad
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [5:0] found_index, [12:6] list_length, zero pad
  logic [0:0]  m_axis_tuser;        // [0] ok

  logic [VAL_W-1:0] shadow_list[$];  // predicted list contents, index 0 first
  list_outcome_t    outcome_q[$];    // expected results, oldest first
  op_row_t          dir_rows[$];
  int               mismatch_count = 0;

  // knobs owned by the stimulus process, read by the drivers
  int tx_idle_pct = 18;
  int rx_idle_pct = 18;
  int hold_req    = 0;   // bumped to ask the receiver for a long hold-off

  always #5 clk = ~clk;

  array_list_insert_delete_search #(
    .DEPTH(LIST_CAP)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Shadow list update for one accepted operation; returns what the block
  // should answer. Equality is on the raw 32-bit pattern.
  function automatic list_outcome_t apply_list_op(input logic [MODE_W-1:0] op,
                                                  input logic [VAL_W-1:0]  val,
                                                  input logic [POS_W-1:0]  pos);
    list_outcome_t res;
    int            hit;
    res.ok  = 1'b0;
    res.idx = '0;
    hit     = -1;
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (hit < 0 && shadow_list[i] === val) hit = i;
    end
    if (op == MODE_INSERT) begin
      // fails past the end or when the store is full
      if (int'(pos) <= shadow_list.size() && shadow_list.size() < LIST_CAP) begin
        shadow_list.insert(int'(pos), val);
        res.ok  = 1'b1;
        res.idx = pos[OUT_IDX_W-1:0];
      end
    end else if (op == MODE_DELETE) begin
      if (hit >= 0) begin
        shadow_list.delete(hit);
        res.ok  = 1'b1;
        res.idx = hit[OUT_IDX_W-1:0];
      end
    end else if (op == MODE_SEARCH) begin
      if (hit >= 0) begin
        res.ok  = 1'b1;
        res.idx = hit[OUT_IDX_W-1:0];
      end
    end
    // unused mode falls through: ok 0, index 0, length unchanged
    res.len = OUT_LEN_W'(shadow_list.size());
    return res;
  endfunction

  // Offer one operation; idles at random first. tvalid is only lowered in the
  // idle loop, so back-to-back transfers keep it high without a glitch.
  task automatic send_op(input op_row_t row);
    list_outcome_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, row.pos, row.val};
    s_axis_tuser  <= row.op;
    do @(posedge clk); while (!s_axis_tready);
    // transfer taken at this edge
    predicted = apply_list_op(row.op, row.val, row.pos);
    if (row.typed) outcome_q.push_back('{row.ok, row.idx, row.len});
    else           outcome_q.push_back(predicted);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each m_axis transfer against the oldest expectation and
  // drives tready. A hold-off request parks tready low for HOLD_CYCLES so the
  // result register stays full and the block has to stall s_axis.
  // --------------------------------------------------------------------------
  int hold_ack  = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    list_outcome_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending, index",
                          int'(m_axis_tdata[5:0]), 0);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tuser[0] !== want.ok)
            report_mismatch("ok", int'(m_axis_tuser[0]), int'(want.ok));
          if (m_axis_tdata[5:0] !== want.idx)
            report_mismatch("found_index", int'(m_axis_tdata[5:0]), int'(want.idx));
          if (m_axis_tdata[12:6] !== want.len)
            report_mismatch("list_length", int'(m_axis_tdata[12:6]), int'(want.len));
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [VAL_W-1:0] val_pool [8];
    op_row_t          row;
    phase_prof_t      prof;
    int               sent;
    int               phase;
    int               phase_len;
    int               r_mode;
    int               r_val;
    int               r_pos;

    val_pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h0000_0005, 32'hAAAA_AAAA, 32'h5555_5555};

    // directed table: op, value, position, typed?, ok, index, length
    // empty list: search miss, delete with no match, insert past end, unused
    dir_rows.push_back('{MODE_SEARCH, 32'h0000_0000, 7'd0,   1'b1, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_DELETE, 32'h0000_0005, 7'd0,   1'b1, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_INSERT, 32'h0000_0009, 7'd1,   1'b1, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_UNUSED, 32'hFFFF_FFFF, 7'd127, 1'b1, 1'b0, 6'd0, 7'd0});
    // build [0, min, max, -1] from the value extremes
    dir_rows.push_back('{MODE_INSERT, 32'h8000_0000, 7'd0,   1'b1, 1'b1, 6'd0, 7'd1});
    dir_rows.push_back('{MODE_INSERT, 32'h7FFF_FFFF, 7'd1,   1'b1, 1'b1, 6'd1, 7'd2});
    dir_rows.push_back('{MODE_INSERT, 32'h0000_0000, 7'd0,   1'b1, 1'b1, 6'd0, 7'd3});
    dir_rows.push_back('{MODE_INSERT, 32'hFFFF_FFFF, 7'd3,   1'b1, 1'b1, 6'd3, 7'd4});
    // position extremes, both past the end
    dir_rows.push_back('{MODE_INSERT, 32'h0000_0001, 7'd127, 1'b1, 1'b0, 6'd0, 7'd4});
    dir_rows.push_back('{MODE_INSERT, 32'h0000_0001, 7'd64,  1'b1, 1'b0, 6'd0, 7'd4});
    // shifts, duplicates and first-match rules go through the predictor
    dir_rows.push_back('{MODE_SEARCH, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_SEARCH, 32'h8000_0000, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_INSERT, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_SEARCH, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_DELETE, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_SEARCH, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_DELETE, 32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_SEARCH, 32'h1234_5678, 7'd99,  1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_UNUSED, 32'h0000_0000, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_DELETE, 32'h8000_0000, 7'd0,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_INSERT, 32'h5555_5555, 7'd2,   1'b0, 1'b0, 6'd0, 7'd0});
    dir_rows.push_back('{MODE_INSERT, 32'hAAAA_AAAA, 7'd1,   1'b0, 1'b0, 6'd0, 7'd0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_op(dir_rows[i]);

    // Random phases. Fill phases lean on inserts so the list reaches the
    // full store; drain phases lean on deletes of present values so it
    // empties again. Values mostly come from the list or a small pool so
    // that deletes and searches hit, often with duplicates present.
    sent  = 0;
    phase = 0;
    while (sent < RAND_OPS) begin
      case (phase % 4)
        0:       prof = PROF_FILL;
        2:       prof = PROF_DRAIN;
        default: prof = PROF_MIX;
      endcase
      // third phase runs flat out on both sides
      tx_idle_pct <= (phase == 2) ? 0 : 18;
      rx_idle_pct <= (phase == 2) ? 0 : 18;
      // long receiver hold-offs while the sender keeps offering
      if (phase == 1 || phase == 5) hold_req <= hold_req + 1;
      phase_len = $urandom_range(100, 180);

      for (int n = 0; n < phase_len && sent < RAND_OPS; n++) begin
        r_mode = $urandom_range(0, 99);
        case (prof)
          PROF_FILL:  row.op = (r_mode < 70) ? MODE_INSERT : (r_mode < 80) ? MODE_DELETE :
                               (r_mode < 95) ? MODE_SEARCH : MODE_UNUSED;
          PROF_DRAIN: row.op = (r_mode < 15) ? MODE_INSERT : (r_mode < 70) ? MODE_DELETE :
                               (r_mode < 95) ? MODE_SEARCH : MODE_UNUSED;
          default:    row.op = (r_mode < 40) ? MODE_INSERT : (r_mode < 70) ? MODE_DELETE :
                               (r_mode < 95) ? MODE_SEARCH : MODE_UNUSED;
        endcase

        r_val = $urandom_range(0, 99);
        if (r_val < 45 && shadow_list.size() > 0)
          row.val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        else if (r_val < 75)
          row.val = val_pool[3'($urandom_range(0, 7))];
        else
          row.val = $urandom;

        // in-range positions dominate; past-end and full 7-bit range also show
        r_pos = $urandom_range(0, 99);
        if (row.op != MODE_INSERT || r_pos >= 90)
          row.pos = POS_W'($urandom_range(0, 127));
        else if (r_pos < 80)
          row.pos = POS_W'($urandom_range(0, shadow_list.size()));
        else
          row.pos = POS_W'($urandom_range(shadow_list.size() + 1, 127));

        row.typed = 1'b0;
        send_op(row);
        sent++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
